### design/look_at_view_matrix_top_defines.svh
// Assertion macros shared by the view matrix design.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LAV_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("look_at_view_matrix assertion failed");
`define LAV_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("look_at_view_matrix forbidden condition seen");
`else
`define LAV_ASSERT(label, prop)
`define LAV_NEVER(label, expr)
`endif
`endif

### design/lav_pkg.sv
`timescale 1ns / 1ps
package lav_pkg;

    localparam int UNIT_LAT  = 70;
    localparam int CROSS_LAT = 2;
    localparam int XLATE_LAT = 3;
    localparam int FW_DLY    = CROSS_LAT + UNIT_LAT;
    localparam int EYE_DLY   = 3 * UNIT_LAT + 2 * CROSS_LAT;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] upward_x;
        logic signed [31:0] upward_y;
        logic signed [31:0] upward_z;
        logic signed [31:0] forward_x;
        logic signed [31:0] forward_y;
        logic signed [31:0] forward_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_out;

    // Position of the highest set bit; zero input gives zero.
    function automatic logic [6:0] msb64(logic [63:0] x);
        logic [6:0] pos;
        pos = '0;
        for (int b = 0; b < 64; b++) begin
            if (x[b]) begin
                pos = 7'(b);
            end
        end
        return pos;
    endfunction

endpackage

### design/lav_delay.sv
`timescale 1ns / 1ps
module lav_delay #(
    parameter int W = 96,
    parameter int D = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sr [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_d = r_sr[D-1];

endmodule

### design/lav_cross.sv
`timescale 1ns / 1ps
module lav_cross (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_a [0:2],
    input  logic signed [31:0] i_b [0:2],
    output logic               o_valid,
    output logic signed [63:0] o_c [0:2]
);

    logic               r1_valid;
    logic signed [63:0] r1_p [0:5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            o_valid  <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= 64'(i_a[1]) * 64'(i_b[2]);
            r1_p[1] <= 64'(i_a[2]) * 64'(i_b[1]);
            r1_p[2] <= 64'(i_a[2]) * 64'(i_b[0]);
            r1_p[3] <= 64'(i_a[0]) * 64'(i_b[2]);
            r1_p[4] <= 64'(i_a[0]) * 64'(i_b[1]);
            r1_p[5] <= 64'(i_a[1]) * 64'(i_b[0]);
            // Operands are bounded so each difference fits in 64 bits.
            o_c[0]  <= r1_p[0] - r1_p[1];
            o_c[1]  <= r1_p[2] - r1_p[3];
            o_c[2]  <= r1_p[4] - r1_p[5];
        end
    end

endmodule

### design/lav_xlate.sv
`timescale 1ns / 1ps
module lav_xlate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_row [0:2],
    input  logic signed [31:0] i_eye [0:2],
    output logic               o_valid,
    output logic signed [31:0] o_shift
);

    logic               r1_valid;
    logic               r2_valid;
    logic signed [63:0] r1_p [0:2];
    logic signed [65:0] r2_t;
    logic signed [35:0] w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
    end

    // Floor of t / 2^30 after adding half rounds to nearest, ties up.
    assign w_q = 36'(r2_t >>> 30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i] <= 64'(i_row[i]) * 64'(i_eye[i]);
            end
            r2_t <= 66'sd536870912 - (66'(r1_p[0]) + 66'(r1_p[1]) + 66'(r1_p[2]));
            if (w_q > 36'sd2147483647) begin
                o_shift <= 32'sh7fffffff;
            end else if (w_q < -36'sd2147483648) begin
                o_shift <= 32'sh80000000;
            end else begin
                o_shift <= w_q[31:0];
            end
        end
    end

endmodule

### design/lav_unit.sv
`timescale 1ns / 1ps
module lav_unit #(
    parameter int W = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [W-1:0] i_v [0:2],
    output logic               o_valid,
    output logic signed [31:0] o_u [0:2]
);

    // Front end: magnitudes, leading one, normalize, squares, sum.
    logic         r1_valid, r2_valid, r3_valid, r4_valid;
    logic [W-1:0] r1_a [0:2];
    logic [W-1:0] r2_a [0:2];
    logic [30:0]  r3_a [0:2];
    logic [30:0]  r4_a [0:2];
    logic [61:0]  r4_sq [0:2];
    logic         r1_neg [0:2];
    logic         r2_neg [0:2];
    logic         r3_neg [0:2];
    logic         r4_neg [0:2];
    logic [6:0]   r2_msb;
    logic         r2_zero, r3_zero, r4_zero;
    logic [W-1:0] w_or;

    // Square root stages.
    logic [63:0]  sq_s [0:32];
    logic [33:0]  sq_r [0:32];
    logic [31:0]  sq_q [0:32];
    logic [30:0]  sq_a [0:32][0:2];
    logic         sq_neg [0:32][0:2];
    logic         sq_zero [0:32];
    logic         sq_v [0:32];

    // Division stages.
    logic [31:0]  dv_rem [0:31][0:2];
    logic [30:0]  dv_n [0:31][0:2];
    logic [30:0]  dv_q [0:31][0:2];
    logic [31:0]  dv_r [0:31];
    logic         dv_neg [0:31][0:2];
    logic         dv_zero [0:31];
    logic         dv_v [0:31];

    assign w_or = r1_a[0] | r1_a[1] | r1_a[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            sq_v[0]  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            sq_v[0]  <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [93:0] wide;
        logic [93:0] sh;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_a[i]   <= i_v[i][W-1] ? W'(-i_v[i]) : W'(i_v[i]);
                r1_neg[i] <= i_v[i][W-1];
                r2_a[i]   <= r1_a[i];
                r2_neg[i] <= r1_neg[i];
                // Right shifts truncate; the largest lands in [2^30, 2^31).
                wide = 94'(r2_a[i]);
                if (r2_msb >= 7'd30) begin
                    sh = wide >> (r2_msb - 7'd30);
                end else begin
                    sh = wide << (7'd30 - r2_msb);
                end
                r3_a[i]   <= sh[30:0];
                r3_neg[i] <= r2_neg[i];
                r4_a[i]   <= r3_a[i];
                r4_neg[i] <= r3_neg[i];
                r4_sq[i]  <= 62'(r3_a[i]) * 62'(r3_a[i]);
                sq_a[0][i]   <= r4_a[i];
                sq_neg[0][i] <= r4_neg[i];
            end
            r2_msb     <= lav_pkg::msb64(64'(w_or));
            r2_zero    <= (w_or == '0);
            r3_zero    <= r2_zero;
            r4_zero    <= r3_zero;
            sq_zero[0] <= r4_zero;
            sq_s[0]    <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
            sq_r[0]    <= '0;
            sq_q[0]    <= '0;
        end
    end

    // One result bit of the square root per stage, two radicand bits each.
    for (genvar g = 0; g < 32; g++) begin : g_sqrt
        localparam int K = 31 - g;
        logic [35:0] n_t;
        logic [35:0] n_trial;
        logic        n_ge;

        always_comb begin
            n_t     = {sq_r[g], sq_s[g][2*K+1 -: 2]};
            n_trial = {2'b00, sq_q[g], 2'b01};
            n_ge    = (n_t >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                sq_v[g+1] <= 1'b0;
            end else if (i_en) begin
                sq_v[g+1] <= sq_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                sq_r[g+1]    <= n_ge ? 34'(n_t - n_trial) : n_t[33:0];
                sq_q[g+1]    <= {sq_q[g][30:0], n_ge};
                sq_s[g+1]    <= sq_s[g];
                sq_a[g+1]    <= sq_a[g];
                sq_neg[g+1]  <= sq_neg[g];
                sq_zero[g+1] <= sq_zero[g];
            end
        end
    end

    // Division setup: numerator a * 2^30 + floor(r / 2).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else if (i_en) begin
            dv_v[0] <= sq_v[32];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [61:0] num;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                num = 62'({sq_a[32][i], 30'b0}) + 62'(sq_q[32][31:1]);
                dv_rem[0][i] <= 32'(num[61:31]);
                dv_n[0][i]   <= num[30:0];
                dv_q[0][i]   <= '0;
            end
            dv_r[0]    <= sq_q[32];
            dv_neg[0]  <= sq_neg[32];
            dv_zero[0] <= sq_zero[32];
        end
    end

    // Restoring division, one quotient bit per stage for each lane.
    for (genvar g = 0; g < 31; g++) begin : g_div
        localparam int J = 30 - g;
        logic [32:0] n_t  [0:2];
        logic        n_ge [0:2];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_t[i]  = {dv_rem[g][i], dv_n[g][i][J]};
                n_ge[i] = (n_t[i] >= {1'b0, dv_r[g]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[g+1] <= 1'b0;
            end else if (i_en) begin
                dv_v[g+1] <= dv_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    dv_rem[g+1][i] <= n_ge[i] ? 32'(n_t[i] - {1'b0, dv_r[g]}) : n_t[i][31:0];
                    dv_q[g+1][i]   <= {dv_q[g][i][29:0], n_ge[i]};
                end
                dv_n[g+1]    <= dv_n[g];
                dv_r[g+1]    <= dv_r[g];
                dv_neg[g+1]  <= dv_neg[g];
                dv_zero[g+1] <= dv_zero[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= dv_v[31];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] mag;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                mag = {1'b0, dv_q[31][i]};
                if (dv_zero[31]) begin
                    o_u[i] <= '0;
                end else begin
                    o_u[i] <= dv_neg[31][i] ? -mag : mag;
                end
            end
        end
    end

endmodule

### design/look_at_view_matrix_top.sv
`timescale 1ns / 1ps
// View transform from eye, target and up vectors (Q16.16 in, Q2.30 rows out).
// Input beats arrive on i_in_valid / o_in_ready / i_in_data, result beats
// leave on o_out_valid / i_out_ready / o_out_data, one result per input beat.
// The pipeline takes one beat per clock while o_in_ready is high. From an
// accepted input beat to o_out_valid it runs through one difference stage,
// three normalize units of 70 stages each (a 32-stage square root and a
// 31-stage divider set the bulk of that), two cross-product units of 2
// stages, a 3-stage translation unit and the output queue register.
// The output queue holds two results. While it has room the whole pipeline
// advances every cycle; once two results wait untaken, o_in_ready drops and
// every stage holds its contents until the receiver takes a beat.
// A synchronous active-low reset empties the pipeline and the queue; the
// data registers are not reset; the first input beat may follow right after.
`include "look_at_view_matrix_top_defines.svh"
module look_at_view_matrix_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lav_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lav_pkg::t_out o_out_data
);

    logic               w_en;
    logic               r0_valid;
    logic signed [32:0] r0_dz [0:2];
    logic signed [31:0] r0_eye [0:2];
    logic signed [31:0] r0_up [0:2];

    logic               w_fw_valid, w_rx_valid, w_rt_valid, w_uy_valid, w_uw_valid;
    logic signed [31:0] w_fw [0:2];
    logic signed [31:0] w_rt [0:2];
    logic signed [31:0] w_uw [0:2];
    logic signed [63:0] w_rx [0:2];
    logic signed [63:0] w_uy [0:2];
    logic signed [31:0] w_up_d [0:2];
    logic signed [31:0] w_fw_d1 [0:2];
    logic signed [31:0] w_fw_d2 [0:2];
    logic signed [31:0] w_rt_d [0:2];
    logic signed [31:0] w_eye_d [0:2];
    logic [95:0]        w_up_p, w_fw_p1, w_fw_p2, w_rt_p, w_eye_p;
    logic               w_sh_valid [0:2];
    logic signed [31:0] w_sh [0:2];

    lav_pkg::t_out      w_res;
    lav_pkg::t_out      r_q0, r_q1;
    logic [1:0]         r_cnt;
    logic               w_push, w_pop;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_dz[0]  <= 33'(i_in_data.eye_x) - 33'(i_in_data.target_x);
            r0_dz[1]  <= 33'(i_in_data.eye_y) - 33'(i_in_data.target_y);
            r0_dz[2]  <= 33'(i_in_data.eye_z) - 33'(i_in_data.target_z);
            r0_eye[0] <= i_in_data.eye_x;
            r0_eye[1] <= i_in_data.eye_y;
            r0_eye[2] <= i_in_data.eye_z;
            r0_up[0]  <= i_in_data.up_x;
            r0_up[1]  <= i_in_data.up_y;
            r0_up[2]  <= i_in_data.up_z;
        end
    end

    lav_unit #(.W(33)) u_unit_fw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r0_valid),
        .i_v(r0_dz), .o_valid(w_fw_valid), .o_u(w_fw)
    );

    lav_delay #(.W(96), .D(lav_pkg::UNIT_LAT)) u_dly_up (
        .i_clk(i_clk), .i_en(w_en), .i_d({r0_up[0], r0_up[1], r0_up[2]}), .o_d(w_up_p)
    );

    assign w_up_d[0] = w_up_p[95:64];
    assign w_up_d[1] = w_up_p[63:32];
    assign w_up_d[2] = w_up_p[31:0];

    lav_cross u_cross_rx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_fw_valid),
        .i_a(w_up_d), .i_b(w_fw), .o_valid(w_rx_valid), .o_c(w_rx)
    );

    lav_unit #(.W(64)) u_unit_rt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_rx_valid),
        .i_v(w_rx), .o_valid(w_rt_valid), .o_u(w_rt)
    );

    lav_delay #(.W(96), .D(lav_pkg::FW_DLY)) u_dly_fw1 (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_fw[0], w_fw[1], w_fw[2]}), .o_d(w_fw_p1)
    );

    assign w_fw_d1[0] = w_fw_p1[95:64];
    assign w_fw_d1[1] = w_fw_p1[63:32];
    assign w_fw_d1[2] = w_fw_p1[31:0];

    lav_cross u_cross_uy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_rt_valid),
        .i_a(w_fw_d1), .i_b(w_rt), .o_valid(w_uy_valid), .o_c(w_uy)
    );

    lav_unit #(.W(64)) u_unit_uw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_uy_valid),
        .i_v(w_uy), .o_valid(w_uw_valid), .o_u(w_uw)
    );

    lav_delay #(.W(96), .D(lav_pkg::FW_DLY)) u_dly_fw2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_fw_p1), .o_d(w_fw_p2)
    );

    lav_delay #(.W(96), .D(lav_pkg::FW_DLY)) u_dly_rt (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_rt[0], w_rt[1], w_rt[2]}), .o_d(w_rt_p)
    );

    lav_delay #(.W(96), .D(lav_pkg::EYE_DLY)) u_dly_eye (
        .i_clk(i_clk), .i_en(w_en), .i_d({r0_eye[0], r0_eye[1], r0_eye[2]}), .o_d(w_eye_p)
    );

    assign w_fw_d2[0] = w_fw_p2[95:64];
    assign w_fw_d2[1] = w_fw_p2[63:32];
    assign w_fw_d2[2] = w_fw_p2[31:0];
    assign w_rt_d[0]  = w_rt_p[95:64];
    assign w_rt_d[1]  = w_rt_p[63:32];
    assign w_rt_d[2]  = w_rt_p[31:0];
    assign w_eye_d[0] = w_eye_p[95:64];
    assign w_eye_d[1] = w_eye_p[63:32];
    assign w_eye_d[2] = w_eye_p[31:0];

    lav_xlate u_xlate_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_uw_valid),
        .i_row(w_rt_d), .i_eye(w_eye_d), .o_valid(w_sh_valid[0]), .o_shift(w_sh[0])
    );

    lav_xlate u_xlate_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_uw_valid),
        .i_row(w_uw), .i_eye(w_eye_d), .o_valid(w_sh_valid[1]), .o_shift(w_sh[1])
    );

    lav_xlate u_xlate_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_uw_valid),
        .i_row(w_fw_d2), .i_eye(w_eye_d), .o_valid(w_sh_valid[2]), .o_shift(w_sh[2])
    );

    // The rotation rows pass through a chain of hold registers, sized by XLATE_LAT, to line up with the shifts.
    logic signed [31:0] r_rt_h [0:2][0:2];
    logic signed [31:0] r_uw_h [0:2][0:2];
    logic signed [31:0] r_fw_h [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rt_h[0] <= w_rt_d;
            r_uw_h[0] <= w_uw;
            r_fw_h[0] <= w_fw_d2;
            for (int k = 1; k < lav_pkg::XLATE_LAT; k++) begin
                r_rt_h[k] <= r_rt_h[k-1];
                r_uw_h[k] <= r_uw_h[k-1];
                r_fw_h[k] <= r_fw_h[k-1];
            end
        end
    end

    always_comb begin
        w_res.right_x   = r_rt_h[2][0];
        w_res.right_y   = r_rt_h[2][1];
        w_res.right_z   = r_rt_h[2][2];
        w_res.upward_x  = r_uw_h[2][0];
        w_res.upward_y  = r_uw_h[2][1];
        w_res.upward_z  = r_uw_h[2][2];
        w_res.forward_x = r_fw_h[2][0];
        w_res.forward_y = r_fw_h[2][1];
        w_res.forward_z = r_fw_h[2][2];
        w_res.shift_x   = w_sh[0];
        w_res.shift_y   = w_sh[1];
        w_res.shift_z   = w_sh[2];
    end

    // Two-entry output queue; the pipeline only moves while it has room.
    assign w_push      = w_en && w_sh_valid[0] && w_sh_valid[1] && w_sh_valid[2];
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (w_push) begin
                r_q0 <= w_res;
            end else begin
                r_q0 <= r_q1;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_res;
            end else begin
                r_q1 <= w_res;
            end
        end
    end

    // A degenerate forward axis forces every row and shift to zero; this checks right_x, upward_y and shift_z.
    `LAV_ASSERT(a_fw_zero, (o_out_valid && o_out_data.forward_x == 0 && o_out_data.forward_y == 0 && o_out_data.forward_z == 0) |-> (o_out_data.right_x == 0 && o_out_data.upward_y == 0 && o_out_data.shift_z == 0))
    // A zero right row leaves nothing for the upward row either.
    `LAV_ASSERT(a_rt_zero, (o_out_valid && o_out_data.right_x == 0 && o_out_data.right_y == 0 && o_out_data.right_z == 0) |-> (o_out_data.upward_x == 0 && o_out_data.upward_y == 0 && o_out_data.upward_z == 0))
    // A held pipeline must not advance its final valid.
    `LAV_ASSERT(a_hold, !w_en |=> $stable(w_sh_valid[0]))
    // The three translation lanes always run in lockstep.
    `LAV_NEVER(a_lanes, w_sh_valid[0] != w_sh_valid[1] || w_sh_valid[0] != w_sh_valid[2])

endmodule
